// ----- sv/text_cell_buffer_dirty_tracker_unit_assert.svh -----
// Assertion macros for the text cell buffer
`ifndef TEXT_CELL_BUFFER_DIRTY_TRACKER_UNIT_ASSERT_SVH
`define TEXT_CELL_BUFFER_DIRTY_TRACKER_UNIT_ASSERT_SVH
`define TCB_ASSERT_IMPL(lbl, a, c) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |-> (c)) \
      else $error("assertion failed");
`define TCB_ASSERT_NEXT(lbl, a, c) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |=> (c)) \
      else $error("assertion failed");
`endif

// ----- sv/tcbdt_pkg.sv -----
//------------------------------------------------------------------------------
// tcbdt_pkg
// Types and constants for the text cell buffer.
//------------------------------------------------------------------------------
`default_nettype none
package tcbdt_pkg;
   localparam int CELLS_DEF = 64;
   localparam int SCREEN_WIDTH_DEF = 128;
   localparam int SCREEN_HEIGHT_DEF = 32;
   localparam int MAX_OUT = 64;
   localparam logic [7:0] SPACE_CH = 8'h20;
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_DRAW = 2'd2;
   localparam logic [1:0] REG_COLS = 2'd0;
   localparam logic [1:0] REG_ROWS = 2'd1;
   localparam logic [1:0] REG_FW = 2'd2;
   localparam logic [1:0] REG_FH = 2'd3;
   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_WRD, ST_WRW, ST_PRE, ST_POST, ST_ROWEND, ST_DRD, ST_DRW,
      ST_DOUT, ST_NONE
   } state_type;
endpackage
`default_nettype wire

// ----- sv/text_cell_buffer_dirty_tracker_unit.sv -----
//------------------------------------------------------------------------------
// text_cell_buffer_dirty_tracker_unit
// Character cell buffer with a changed mark per cell, one memory of cells.
//------------------------------------------------------------------------------
// Write character: accept, memory read, then compare and write back; no new item is
// taken meanwhile. Clear: a pass over all cells. String end with clear_row: cells
// before the text are checked, the row end is found, and cells after are cleared.
// Draw: scans the cells, stalling while results wait; the next item waits for the
// last result. Reset runs a clear pass over all cells, no item taken.
// Reset is synchronous and active high.
`default_nettype none
module text_cell_buffer_dirty_tracker_unit #(
   parameter int CELLS = tcbdt_pkg::CELLS_DEF,
   parameter int SCREEN_WIDTH = tcbdt_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = tcbdt_pkg::SCREEN_HEIGHT_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_op,
   input  wire logic       req_first,
   input  wire logic [5:0] req_row,
   input  wire logic [5:0] req_col,
   input  wire logic [7:0] req_ch,
   input  wire logic [1:0] req_style,
   input  wire logic       req_clear_row,
   input  wire logic       req_wrap,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [6:0]      rsp_x,
   output logic [5:0]      rsp_y,
   output logic [7:0]      rsp_out_char,
   output logic [1:0]      rsp_out_style,
   output logic            rsp_last,
   output logic            rsp_none,
   input  wire logic       csr_write,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_data
);
   import tcbdt_pkg::*;
   localparam int AW = $clog2(CELLS);
   localparam int IW = (AW > 6 ? AW : 6) + 8;
   localparam int XW = $clog2(SCREEN_WIDTH) > 7 ? $clog2(SCREEN_WIDTH) : 7;
   localparam int YW = $clog2(SCREEN_HEIGHT) > 6 ? $clog2(SCREEN_HEIGHT) : 6;

   logic [10:0] mem [CELLS];
   logic [10:0] rd_ff;
   logic [AW-1:0] ra, wa;
   logic we;
   logic [10:0] wd;

   state_type st_ff, st_in;
   logic [6:0] cols_ff, rows_ff;
   logic [7:0] fw_ff;
   logic [6:0] fh_ff;
   logic [IW-1:0] ws_ff, ws_in, wc_ff, wc_in, wstop_ff, wstop_in, wrb_ff, wrb_in;
   logic [IW-1:0] j_ff, j_in, end_ff, end_in;
   logic [1:0] wf_ff, wf_in, wsty_ff, wsty_in;
   logic [7:0] ch_ff, ch_in;
   logic [6:0] n_ff, n_in;
   logic [6:0] ccol_ff, ccol_in;
   logic [XW-1:0] x_ff, x_in;
   logic [YW-1:0] y_ff, y_in;
   logic [9:0] od_ff, od_in;
   logic [9:0] pd_ff, pd_in;
   logic [6:0] px_ff, px_in, ppx_ff, ppx_in;
   logic [5:0] py_ff, py_in, ppy_ff, ppy_in;
   logic ov_ff, ov_in, ol_ff, ol_in, on_ff, on_in;
   logic [13:0] prod;
   logic [IW-1:0] cnt, idx, rbase;
   logic acc;

   assign prod = 14'(cols_ff) * 14'(rows_ff);
   assign cnt = (prod > 14'(CELLS)) ? IW'(CELLS) : IW'(prod);
   assign idx = ws_ff + wc_ff;
   assign rbase = IW'(req_row) * IW'(cols_ff);

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[ra];
   end

   assign req_ready = (st_ff == ST_IDLE) && !ov_ff;
   assign acc = req_valid && req_ready;

   always_comb begin
      st_in = st_ff;
      ws_in = ws_ff; wc_in = wc_ff; wstop_in = wstop_ff; wrb_in = wrb_ff;
      wf_in = wf_ff; wsty_in = wsty_ff; ch_in = ch_ff;
      j_in = j_ff; end_in = end_ff; n_in = n_ff; ccol_in = ccol_ff;
      x_in = x_ff; y_in = y_ff; od_in = od_ff;
      pd_in = pd_ff; px_in = px_ff; py_in = py_ff; ppx_in = ppx_ff; ppy_in = ppy_ff;
      ov_in = ov_ff; ol_in = ol_ff; on_in = on_ff;
      ra = j_ff[AW-1:0]; wa = j_ff[AW-1:0]; we = 1'b0;
      wd = {1'b1, 2'd0, SPACE_CH};
      if (ov_ff && rsp_ready) ov_in = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (acc) begin
               case (req_op)
                  OP_CLEAR: begin j_in = '0; st_in = ST_CLEAR; end
                  OP_WRITE: begin
                     if (req_first) begin
                        wf_in = 2'b00;
                        if (7'(req_row) < rows_ff && 7'(req_col) < cols_ff) begin
                           wrb_in = rbase;
                           ws_in = rbase + IW'(req_col);
                           wstop_in = req_wrap ? cnt : rbase + IW'(cols_ff);
                           wc_in = '0;
                           wsty_in = req_style;
                           wf_in = {req_clear_row, 1'b1};
                        end
                     end
                     if (req_first ? (7'(req_row) < rows_ff && 7'(req_col) < cols_ff)
                                   : wf_ff[0]) begin
                        if (req_ch == 8'd0) begin
                           wf_in = 2'b00;
                           if (req_first ? req_clear_row : wf_ff[1]) begin
                              j_in = req_first ? rbase : wrb_ff;
                              st_in = ST_PRE;
                           end
                        end else begin
                           ch_in = req_ch;
                           st_in = ST_WRD;
                        end
                     end
                  end
                  OP_DRAW: begin
                     j_in = '0; n_in = '0; ccol_in = '0; x_in = '0; y_in = '0;
                     st_in = ST_DRD;
                  end
                  default: ;
               endcase
            end
         end
         ST_CLEAR: begin
            we = 1'b1;
            j_in = j_ff + IW'(1);
            if (j_ff == IW'(CELLS - 1)) st_in = ST_IDLE;
         end
         ST_WRD: begin
            ra = idx[AW-1:0];
            if (idx < wstop_ff && idx < cnt) st_in = ST_WRW;
            else st_in = ST_IDLE;
         end
         ST_WRW: begin
            wa = idx[AW-1:0];
            if (rd_ff[7:0] != ch_ff || rd_ff[9:8] != wsty_ff) begin
               we = 1'b1; wd = {1'b1, wsty_ff, ch_ff};
            end
            wc_in = wc_ff + IW'(1);
            st_in = ST_IDLE;
         end
         ST_PRE: begin
            if (j_ff < cnt && j_ff < ws_ff) begin
               ra = j_ff[AW-1:0];
               st_in = ST_POST;
            end else begin
               j_in = idx;
               n_in = 7'd1;
               st_in = ST_DRD;
               if (cols_ff == 7'd0) end_in = '0;
               else if (wc_ff == '0) end_in = wrb_ff + IW'(cols_ff);
               else begin
                  end_in = '0;
                  st_in = ST_ROWEND;
               end
            end
         end
         ST_POST: begin
            if (rd_ff[7:0] != SPACE_CH) we = 1'b1;
            j_in = j_ff + IW'(1);
            st_in = ST_PRE;
         end
         ST_ROWEND: begin
            if (end_ff < idx && end_ff < cnt) end_in = end_ff + IW'(cols_ff);
            else st_in = ST_DRD;
         end
         ST_DRD: begin
            if (n_ff == 7'd1) begin
               if (j_ff < cnt && j_ff < end_ff) begin
                  we = 1'b1;
                  j_in = j_ff + IW'(1);
               end else begin
                  n_in = '0; st_in = ST_IDLE;
               end
            end else if (j_ff < cnt && n_ff < 7'(MAX_OUT)) begin
               ra = j_ff[AW-1:0];
               st_in = ST_DOUT;
            end else if (n_ff == '0) begin
               st_in = ST_NONE;
            end else begin
               ol_in = 1'b1; st_in = ST_IDLE;
            end
         end
         ST_DOUT: begin
            if (!ov_ff || rsp_ready) begin
               if (rd_ff[10]) begin
                  we = 1'b1; wd = {1'b0, rd_ff[9:0]};
                  if (n_ff != '0) begin
                     ov_in = 1'b1; ol_in = 1'b0; on_in = 1'b0;
                     od_in = pd_ff; px_in = ppx_ff; py_in = ppy_ff;
                  end
                  pd_in = rd_ff[9:0]; ppx_in = x_ff[6:0]; ppy_in = y_ff[5:0];
                  n_in = n_ff + 7'd1;
               end
               j_in = j_ff + IW'(1);
               if (ccol_ff + 7'd1 >= cols_ff) begin
                  ccol_in = '0; x_in = '0; y_in = y_ff + YW'(fh_ff);
               end else begin
                  ccol_in = ccol_ff + 7'd1; x_in = x_ff + XW'(fw_ff);
               end
               st_in = ST_DRW;
            end
         end
         ST_DRW: begin
            if (!ov_ff || rsp_ready) begin
               if (j_ff < cnt && n_ff < 7'(MAX_OUT)) begin
                  ra = j_ff[AW-1:0];
                  st_in = ST_DOUT;
               end else if (n_ff == '0) st_in = ST_NONE;
               else begin
                  ov_in = 1'b1; ol_in = 1'b1; on_in = 1'b0;
                  od_in = pd_ff; px_in = ppx_ff; py_in = ppy_ff;
                  st_in = ST_IDLE;
               end
            end
         end
         ST_NONE: begin
            if (!ov_ff) begin
               ov_in = 1'b1; ol_in = 1'b1; on_in = 1'b1; od_in = '0;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      od_ff <= od_in;
      px_ff <= px_in;
      py_ff <= py_in;
      pd_ff <= pd_in;
      ppx_ff <= ppx_in;
      ppy_ff <= ppy_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_CLEAR; j_ff <= '0;
         cols_ff <= 7'd16; rows_ff <= 7'd2; fw_ff <= 8'd8; fh_ff <= 7'd16;
         ws_ff <= '0; wc_ff <= '0; wstop_ff <= '0; wrb_ff <= '0;
         wf_ff <= '0; wsty_ff <= '0; ov_ff <= 1'b0; ol_ff <= 1'b0; on_ff <= 1'b0;
         n_ff <= '0; end_ff <= '0; ccol_ff <= '0; x_ff <= '0; y_ff <= '0;
         ch_ff <= '0;
      end else begin
         st_ff <= st_in; j_ff <= j_in;
         ws_ff <= ws_in; wc_ff <= wc_in; wstop_ff <= wstop_in; wrb_ff <= wrb_in;
         wf_ff <= wf_in; wsty_ff <= wsty_in; ch_ff <= ch_in;
         ov_ff <= ov_in; ol_ff <= ol_in; on_ff <= on_in; n_ff <= n_in;
         end_ff <= end_in; ccol_ff <= ccol_in; x_ff <= x_in; y_ff <= y_in;
         if (csr_write) begin
            case (csr_index)
               REG_COLS: cols_ff <= csr_data[6:0];
               REG_ROWS: rows_ff <= csr_data[6:0];
               REG_FW: fw_ff <= csr_data;
               REG_FH: fh_ff <= csr_data[6:0];
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_x = on_ff ? 7'd0 : px_ff;
   assign rsp_y = on_ff ? 6'd0 : py_ff;
   assign rsp_out_char = od_ff[7:0];
   assign rsp_out_style = od_ff[9:8];
   assign rsp_last = ol_ff;
   assign rsp_none = on_ff;

`include "text_cell_buffer_dirty_tracker_unit_assert.svh"
   `TCB_ASSERT_IMPL(a_none_last, rsp_valid && rsp_none, rsp_last)
   `TCB_ASSERT_IMPL(a_busy_out, rsp_valid, !req_ready)
   `TCB_ASSERT_NEXT(a_hold, rsp_valid && !rsp_ready, rsp_valid)
endmodule
`default_nettype wire
